[src/acsi_rx_pkg.sv]
// Shared types, constants and decode functions for the ACSI/SCSI command receiver.
// Depends on nothing; imported by acsi_scsi_command_receiver_core.
package acsi_rx_pkg;

    // Command store geometry
    localparam int MAX_CMD_BYTES = 17;
    localparam int STORE_AW      = $clog2(MAX_CMD_BYTES);

    // Framing constants
    localparam logic [7:0] ICD_PREFIX   = 8'h1f;
    localparam logic [7:0] GROUP_MASK   = 8'he0;
    localparam logic [7:0] OPCODE_MASK  = 8'h1f;
    localparam logic [2:0] ID_MASK      = 3'h7;
    localparam logic [4:0] BASE_CMD_LEN = 5'd6;

    // Result status codes
    localparam logic [1:0] ST_CMD_BYTE    = 2'd0;
    localparam logic [1:0] ST_NOT_ENABLED = 2'd1;
    localparam logic [1:0] ST_BUS_ERROR   = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_SCSI_MODE   = 1'b0;
    localparam logic REG_ENABLED_IDS = 1'b1;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       start_req;
        logic       bus_error;
    } acsi_rx_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [4:0] byte_index;
        logic       last;
        logic [1:0] status;
    } acsi_rx_out_t;

    // ACSI length from byte 0 and the group bits of byte 1 (ICD commands)
    function automatic logic [4:0] acsi_len(input logic [7:0] b0, input logic [7:0] b1);
        logic [2:0] grp;
        grp = 3'((b1 & GROUP_MASK) >> 5);
        if ((b0 & OPCODE_MASK) != OPCODE_MASK)
            return BASE_CMD_LEN;
        unique case (grp)
            3'd1, 3'd2: return 5'd11;
            3'd5:       return 5'd13;
            default:    return 5'd7;
        endcase
    endfunction

    // SCSI length from the group code of the opcode byte
    function automatic logic [4:0] scsi_len(input logic [7:0] b0);
        logic [2:0] grp;
        grp = 3'((b0 & GROUP_MASK) >> 5);
        unique case (grp)
            3'd1, 3'd2: return 5'd10;
            3'd4:       return 5'd16;
            3'd5:       return 5'd12;
            default:    return BASE_CMD_LEN;
        endcase
    endfunction

    // Position of the lowest set bit of a nonzero byte
    function automatic logic [2:0] lowest_id(input logic [7:0] hits);
        logic [2:0] id;
        id = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (hits[i])
                id = 3'(i);
        end
        return id;
    endfunction

endpackage

[src/acsi_scsi_command_receiver_core.sv]
// ACSI/SCSI command receiver: collects command bytes into a store memory and
// replays them as a normalized ACSI/ICD command. Depends on acsi_rx_pkg.
//
// Usage:
//   in channel  (in_valid / in_stall / in_data): one bus byte per transfer,
//     with start_req marking the first byte and bus_error a failed handshake.
//   out channel (out_valid / out_stall / out_data): one result per transfer.
//   cfg port    (cfg_we / cfg_index / cfg_data): index 0 scsi_mode (bit 0),
//     index 1 enabled_ids; write while the block is idle.
// Timing:
//   A byte is taken while collecting and the output is free. A status result
//   (target not enabled, bus error) shows in the cycle after its transfer.
//   On the byte that completes a command the block holds in_stall and drains
//   the store: each result byte goes through a memory read (S_RD), then an
//   output register load (S_LD) that waits while the receiver stalls.
// Stall: a stalled result holds in the output register; input is stalled
//   while a result waits and cannot be replaced, and during the drain.
// Reset: idle, scsi_mode 0, enabled_ids 0; the store memory is not cleared
//   and needs no clearing pass, since only bytes written for the current
//   command are replayed.
module acsi_scsi_command_receiver_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  acsi_rx_pkg::acsi_rx_in_t  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output acsi_rx_pkg::acsi_rx_out_t out_data,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [7:0]                cfg_data
);
    import acsi_rx_pkg::*;

    typedef enum logic [2:0] {
        S_RX = 3'b001,
        S_RD = 3'b010,
        S_LD = 3'b100
    } state_t;

    // Command store
    logic [7:0] store_mem [MAX_CMD_BYTES];
    logic [7:0] rd_data_reg;
    logic [STORE_AW-1:0] rd_addr;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;

    state_t state_reg, state_next;
    logic       scsi_mode_reg;
    logic [7:0] enabled_ids_reg;
    logic [4:0] br_reg, br_next;
    logic [4:0] exp_reg, exp_next;
    logic [2:0] tid_reg, tid_next;
    logic       recv_reg, recv_next;
    logic [7:0] b0_reg, b0_next;
    logic [4:0] drain_idx_reg, drain_idx_next;
    logic [4:0] drain_len_reg, drain_len_next;
    logic       shift_reg, shift_next;
    logic       scsi_out_reg, scsi_out_next;
    logic         out_valid_reg, out_valid_next;
    acsi_rx_out_t out_data_reg, out_data_next;

    logic       out_free;
    logic       in_xfer;
    logic [7:0] hits;
    logic [2:0] acsi_id;
    logic [4:0] br_inc;
    logic [4:0] len_cmb;
    logic       last_cmb;
    logic [7:0] fmt_byte;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_RX) || !out_free;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign hits    = in_data.bus_byte & enabled_ids_reg;
    assign acsi_id = 3'(in_data.bus_byte >> 5) & ID_MASK;
    assign br_inc  = br_reg + 5'd1;
    // A start byte that is stored (ACSI mode) lands in entry 0
    assign wr_addr = in_data.start_req ? {STORE_AW{1'b0}} : br_reg[STORE_AW-1:0];

    // Drain read address: a shifted command reads one entry behind its output index
    assign rd_addr = (shift_reg && drain_idx_reg != 5'd0) ?
                     STORE_AW'(drain_idx_reg - 5'd1) : drain_idx_reg[STORE_AW-1:0];
    assign last_cmb = (drain_idx_reg == drain_len_reg - 5'd1);

    // Format drained byte: in SCSI mode prefix or merge the target ID into byte 0
    always_comb
    begin
        fmt_byte = rd_data_reg;
        if (drain_idx_reg == 5'd0)
        begin
            if (shift_reg)
                fmt_byte = ICD_PREFIX | {tid_reg, 5'd0};
            else if (scsi_out_reg)
                fmt_byte = rd_data_reg | {tid_reg, 5'd0};
        end
    end

    // Collect, decode and sequence the drain
    always_comb
    begin
        state_next     = state_reg;
        br_next        = br_reg;
        exp_next       = exp_reg;
        tid_next       = tid_reg;
        recv_next      = recv_reg;
        b0_next        = b0_reg;
        drain_idx_next = drain_idx_reg;
        drain_len_next = drain_len_reg;
        shift_next     = shift_reg;
        scsi_out_next  = scsi_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        len_cmb        = exp_reg;

        unique case (state_reg)
            S_RX:
            begin
                if (in_xfer && in_data.start_req)
                begin
                    recv_next = 1'b0;
                    if (in_data.bus_error)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{8'd0, 5'd0, 1'b1, ST_BUS_ERROR};
                    end
                    else if (scsi_mode_reg)
                    begin
                        if (hits == 8'd0)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{8'd0, 5'd0, 1'b1, ST_NOT_ENABLED};
                        end
                        else
                        begin
                            tid_next  = lowest_id(hits);
                            br_next   = 5'd0;
                            exp_next  = BASE_CMD_LEN;
                            recv_next = 1'b1;
                        end
                    end
                    else
                    begin
                        tid_next = acsi_id;
                        if (!enabled_ids_reg[acsi_id])
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{8'd0, 5'd0, 1'b1, ST_NOT_ENABLED};
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            b0_next   = in_data.bus_byte;
                            br_next   = 5'd1;
                            exp_next  = BASE_CMD_LEN;
                            recv_next = 1'b1;
                        end
                    end
                end
                else if (in_xfer && recv_reg)
                begin
                    if (in_data.bus_error)
                    begin
                        recv_next      = 1'b0;
                        out_valid_next = 1'b1;
                        out_data_next  = '{8'd0, 5'd0, 1'b1, ST_BUS_ERROR};
                    end
                    else
                    begin
                        wr_en   = (br_reg < 5'(MAX_CMD_BYTES));
                        br_next = br_inc;
                        if (br_reg == 5'd0)
                            b0_next = in_data.bus_byte;
                        if (scsi_mode_reg && br_inc == 5'd1)
                            exp_next = scsi_len(in_data.bus_byte);
                        else if (!scsi_mode_reg && br_inc == 5'd2)
                            exp_next = acsi_len(b0_reg, in_data.bus_byte);
                        len_cmb = exp_next;
                        // Complete: latch framing and start the drain
                        if (br_inc >= exp_next)
                        begin
                            recv_next      = 1'b0;
                            scsi_out_next  = scsi_mode_reg;
                            shift_next     = scsi_mode_reg && len_cmb > BASE_CMD_LEN &&
                                             len_cmb < 5'(MAX_CMD_BYTES);
                            drain_len_next = shift_next ? len_cmb + 5'd1 : len_cmb;
                            drain_idx_next = 5'd0;
                            state_next     = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{fmt_byte, drain_idx_reg, last_cmb, ST_CMD_BYTE};
                    drain_idx_next = drain_idx_reg + 5'd1;
                    state_next     = last_cmb ? S_RX : S_RD;
                end
            end
            default:
            begin
                state_next = S_RX;
            end
        endcase
    end

    // Store write on collect, registered read on drain
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= in_data.bus_byte;
        rd_data_reg <= store_mem[rd_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_RX;
            br_reg          <= 5'd0;
            exp_reg         <= BASE_CMD_LEN;
            tid_reg         <= 3'd0;
            recv_reg        <= 1'b0;
            drain_idx_reg   <= 5'd0;
            drain_len_reg   <= 5'd0;
            shift_reg       <= 1'b0;
            scsi_out_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            scsi_mode_reg   <= 1'b0;
            enabled_ids_reg <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            br_reg        <= br_next;
            exp_reg       <= exp_next;
            tid_reg       <= tid_next;
            recv_reg      <= recv_next;
            drain_idx_reg <= drain_idx_next;
            drain_len_reg <= drain_len_next;
            shift_reg     <= shift_next;
            scsi_out_reg  <= scsi_out_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SCSI_MODE:   scsi_mode_reg   <= cfg_data[0];
                    REG_ENABLED_IDS: enabled_ids_reg <= cfg_data;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        b0_reg       <= b0_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_stall_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RX) |-> in_stall)
        else $error("input taken during drain");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_CMD_BYTE) |-> out_data_reg.last)
        else $error("status result without last");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LD) |-> (drain_idx_reg < drain_len_reg &&
                                 drain_len_reg <= 5'(MAX_CMD_BYTES)))
        else $error("drain index out of range");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LD && out_free && last_cmb) |=> (state_reg == S_RX && out_valid_reg))
        else $error("drain did not return to collect");

    a_no_collect_while_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RX) |-> !recv_reg)
        else $error("receiving flag set during drain");
`endif

endmodule
